@@ sv/pgn_pkg.sv @@
// shared constants and types for the polar gaussian noise generator
// no dependencies; imported by every module of the block
package pgn_pkg;

	localparam int Q15_W      = 16;
	localparam int RAD_BITS   = 31;
	localparam int QROOT_W    = 31;
	localparam int LOG_FRAC_W = 16;
	localparam int LOG_INT_W  = 5;
	localparam int L_W        = LOG_INT_W + LOG_FRAC_W;
	localparam int LN_CONST_W = 31;
	localparam int E_W        = 22;
	localparam int SROOT_W    = 19;
	localparam int MEAN_W     = 16;
	localparam int SCALE_W    = 15;
	localparam int CFG_W      = 16;
	localparam int NUM_W      = 51;

	// 2 ln 2 in q.30
	localparam logic [LN_CONST_W-1:0] TWO_LN2_Q30 = 31'd1488522236;
	localparam logic [SCALE_W-1:0]    SCALE_RESET = 15'd4096;

	localparam logic REG_MEAN  = 1'b0;
	localparam logic REG_SCALE = 1'b1;

	typedef logic signed [Q15_W-1:0] q15_t;

	typedef struct packed {
		q15_t                x;
		q15_t                y;
		logic [RAD_BITS-1:0] r;
	} pair_t;

	typedef struct packed {
		q15_t               x;
		q15_t               y;
		logic [QROOT_W-1:0] q;
	} coord_t;

endpackage

@@ sv/pgn_isqrt.sv @@
// pipelined integer square root, one result bit per stage, with side data
// depends on pgn_pkg
module pgn_isqrt #(
	parameter int RAD_W  = 38,
	parameter int SIDE_W = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 vld_i,
	input  logic [RAD_W-1:0]     rad_i,
	input  logic [SIDE_W-1:0]    side_i,
	output logic                 vld_o,
	output logic [RAD_W/2-1:0]   root_o,
	output logic [SIDE_W-1:0]    side_o
);
	import pgn_pkg::*;

	localparam int STEPS = RAD_W / 2;
	localparam int ACC_W = RAD_W + 1;

	logic [ACC_W-1:0]  rem_s  [STEPS];
	logic [ACC_W-1:0]  res_s  [STEPS];
	logic [SIDE_W-1:0] side_s [STEPS];
	logic              vld_s  [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam logic [ACC_W-1:0] BIT = ACC_W'(1) << (2 * (STEPS - 1 - k));
		logic [ACC_W-1:0]  rem_p;
		logic [ACC_W-1:0]  res_p;
		logic [ACC_W-1:0]  trial;
		logic [SIDE_W-1:0] side_p;
		logic              vld_p;

		if (k == 0) begin : g_first
			assign rem_p  = ACC_W'(rad_i);
			assign res_p  = '0;
			assign side_p = side_i;
			assign vld_p  = vld_i;
		end else begin : g_next
			assign rem_p  = rem_s[k-1];
			assign res_p  = res_s[k-1];
			assign side_p = side_s[k-1];
			assign vld_p  = vld_s[k-1];
		end

		assign trial = res_p + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k] <= side_p;
				if (rem_p >= trial) begin
					rem_s[k] <= rem_p - trial;
					res_s[k] <= (res_p >> 1) + BIT;
				end else begin
					rem_s[k] <= rem_p;
					res_s[k] <= res_p >> 1;
				end
			end
		end
	end

	assign vld_o  = vld_s[STEPS-1];
	assign root_o = res_s[STEPS-1][STEPS-1:0];
	assign side_o = side_s[STEPS-1];

endmodule

@@ sv/pgn_log.sv @@
// pipelined -2 ln r: normalise, sixteen squaring stages for log2, then scale by 2 ln 2
// depends on pgn_pkg
module pgn_log #(
	parameter int SIDE_W = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         vld_i,
	input  logic [pgn_pkg::RAD_BITS-1:0] r_i,
	input  logic [SIDE_W-1:0]            side_i,
	output logic                         vld_o,
	output logic [pgn_pkg::E_W-1:0]      e_o,
	output logic [SIDE_W-1:0]            side_o
);
	import pgn_pkg::*;

	logic [LOG_INT_W-1:0] top_n;
	logic [LOG_INT_W-1:0] sh_n;
	logic [RAD_BITS-1:0]  m_n;

	logic [RAD_BITS-1:0]  m_s1;
	logic [LOG_INT_W-1:0] sh_s1;
	logic [SIDE_W-1:0]    side_s1;
	logic                 vld_s1;

	logic [RAD_BITS-1:0]   it_m_s    [LOG_FRAC_W];
	logic [LOG_FRAC_W-1:0] it_frac_s [LOG_FRAC_W];
	logic [LOG_INT_W-1:0]  it_sh_s   [LOG_FRAC_W];
	logic [SIDE_W-1:0]     it_side_s [LOG_FRAC_W];
	logic                  it_vld_s  [LOG_FRAC_W];

	logic [L_W-1:0]            l_s18;
	logic [SIDE_W-1:0]         side_s18;
	logic                      vld_s18;
	logic [L_W+LN_CONST_W-1:0] prod;
	logic [E_W-1:0]            e_s19;
	logic [SIDE_W-1:0]         side_s19;
	logic                      vld_s19;

	// leading one of r
	always_comb begin
		top_n = '0;
		for (int i = 0; i < RAD_BITS; i++) begin
			if (r_i[i]) begin
				top_n = LOG_INT_W'(i);
			end
		end
	end

	assign sh_n = LOG_INT_W'(RAD_BITS - 1) - top_n;
	assign m_n  = r_i << sh_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s1    <= m_n;
			sh_s1   <= sh_n;
			side_s1 <= side_i;
		end
	end

	for (genvar k = 0; k < LOG_FRAC_W; k++) begin : g_iter
		logic [RAD_BITS-1:0]   m_p;
		logic [LOG_FRAC_W-1:0] frac_p;
		logic [LOG_INT_W-1:0]  sh_p;
		logic [SIDE_W-1:0]     side_p;
		logic                  vld_p;
		logic [2*RAD_BITS-1:0] sq;
		logic [RAD_BITS:0]     t;

		if (k == 0) begin : g_first
			assign m_p    = m_s1;
			assign frac_p = '0;
			assign sh_p   = sh_s1;
			assign side_p = side_s1;
			assign vld_p  = vld_s1;
		end else begin : g_next
			assign m_p    = it_m_s[k-1];
			assign frac_p = it_frac_s[k-1];
			assign sh_p   = it_sh_s[k-1];
			assign side_p = it_side_s[k-1];
			assign vld_p  = it_vld_s[k-1];
		end

		assign sq = m_p * m_p;
		assign t  = sq[2*RAD_BITS-1:RAD_BITS-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				it_vld_s[k] <= 1'b0;
			end else if (adv) begin
				it_vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				it_m_s[k]    <= t[RAD_BITS] ? t[RAD_BITS:1] : t[RAD_BITS-1:0];
				it_frac_s[k] <= {frac_p[LOG_FRAC_W-2:0], t[RAD_BITS]};
				it_sh_s[k]   <= sh_p;
				it_side_s[k] <= side_p;
			end
		end
	end

	assign prod = l_s18 * TWO_LN2_Q30;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s18 <= 1'b0;
			vld_s19 <= 1'b0;
		end else if (adv) begin
			vld_s18 <= it_vld_s[LOG_FRAC_W-1];
			vld_s19 <= vld_s18;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			l_s18    <= {it_sh_s[LOG_FRAC_W-1], LOG_FRAC_W'(0)}
				- L_W'(it_frac_s[LOG_FRAC_W-1]);
			side_s18 <= it_side_s[LOG_FRAC_W-1];
			e_s19    <= prod[LN_CONST_W-1+E_W-1:LN_CONST_W-1];
			side_s19 <= side_s18;
		end
	end

	assign vld_o  = vld_s19;
	assign e_o    = e_s19;
	assign side_o = side_s19;

endmodule

@@ sv/pgn_lane.sv @@
// one output lane: |v| * s * scale, rounded divide by 2q, sign, mean and saturation
// depends on pgn_pkg
module pgn_lane #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic                               vld_i,
	input  pgn_pkg::q15_t                      coord_i,
	input  logic [pgn_pkg::SROOT_W-1:0]        s_i,
	input  logic [pgn_pkg::QROOT_W-1:0]        q_i,
	input  logic [pgn_pkg::SCALE_W-1:0]        scale_i,
	input  logic signed [pgn_pkg::MEAN_W-1:0]  mean_i,
	output logic                               vld_o,
	output logic signed [SAMPLE_WIDTH-1:0]     sample_o
);
	import pgn_pkg::*;

	localparam int QB    = ((SAMPLE_WIDTH > MEAN_W) ? SAMPLE_WIDTH : MEAN_W) + 2;
	localparam int SUM_W = QB + 2;
	localparam int P_W   = Q15_W + SROOT_W;
	localparam int PS_W  = P_W + SCALE_W;
	localparam int DIV_W = QROOT_W + 1;
	localparam logic signed [SUM_W-1:0] HI =
		$signed(SUM_W'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}}));
	localparam logic signed [SUM_W-1:0] LO = -HI - SUM_W'(1);

	logic [Q15_W-1:0]   mag_n;
	logic [P_W-1:0]     p_s1;
	logic [QROOT_W-1:0] q_s1;
	logic               neg_s1;
	logic               vld_s1;

	logic [PS_W-1:0]  ps_n;
	logic [NUM_W-1:0] num_s2;
	logic [DIV_W-1:0] dq_s2;
	logic             neg_s2;
	logic             vld_s2;

	logic [NUM_W-1:0] rem_s3;
	logic [DIV_W-1:0] dq_s3;
	logic             ovf_s3;
	logic             neg_s3;
	logic             vld_s3;

	logic [NUM_W-1:0] dv_rem_s  [QB];
	logic [QB-1:0]    dv_quot_s [QB];
	logic [DIV_W-1:0] dv_dq_s   [QB];
	logic             dv_ovf_s  [QB];
	logic             dv_neg_s  [QB];
	logic             dv_vld_s  [QB];

	logic [QB-1:0]           magq;
	logic signed [SUM_W-1:0] mag_x;
	logic signed [SUM_W-1:0] sv;
	logic signed [SUM_W-1:0] sum;
	logic signed [SAMPLE_WIDTH-1:0] sample_n;
	logic signed [SAMPLE_WIDTH-1:0] sample_s;
	logic                           vld_sf;

	assign mag_n = coord_i[Q15_W-1] ? Q15_W'(-coord_i) : coord_i;
	assign ps_n  = p_s1 * scale_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1   <= mag_n * s_i;
			q_s1   <= q_i;
			neg_s1 <= coord_i[Q15_W-1];
			num_s2 <= NUM_W'(ps_n) + NUM_W'(q_s1);
			dq_s2  <= {q_s1, 1'b0};
			neg_s2 <= neg_s1;
			rem_s3 <= num_s2;
			dq_s3  <= dq_s2;
			ovf_s3 <= (num_s2 >> QB) >= NUM_W'(dq_s2);
			neg_s3 <= neg_s2;
		end
	end

	// restoring divide, one quotient bit per stage, msb first
	for (genvar k = 0; k < QB; k++) begin : g_div
		logic [NUM_W-1:0] rem_p;
		logic [QB-1:0]    quot_p;
		logic [DIV_W-1:0] dq_p;
		logic             ovf_p;
		logic             neg_p;
		logic             vld_p;
		logic             take;

		if (k == 0) begin : g_first
			assign rem_p  = rem_s3;
			assign quot_p = '0;
			assign dq_p   = dq_s3;
			assign ovf_p  = ovf_s3;
			assign neg_p  = neg_s3;
			assign vld_p  = vld_s3;
		end else begin : g_next
			assign rem_p  = dv_rem_s[k-1];
			assign quot_p = dv_quot_s[k-1];
			assign dq_p   = dv_dq_s[k-1];
			assign ovf_p  = dv_ovf_s[k-1];
			assign neg_p  = dv_neg_s[k-1];
			assign vld_p  = dv_vld_s[k-1];
		end

		assign take = !ovf_p && ((rem_p >> (QB - 1 - k)) >= NUM_W'(dq_p));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k] <= 1'b0;
			end else if (adv) begin
				dv_vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_dq_s[k]  <= dq_p;
				dv_ovf_s[k] <= ovf_p;
				dv_neg_s[k] <= neg_p;
				if (take) begin
					dv_rem_s[k]  <= rem_p - (NUM_W'(dq_p) << (QB - 1 - k));
					dv_quot_s[k] <= quot_p | (QB'(1) << (QB - 1 - k));
				end else begin
					dv_rem_s[k]  <= rem_p;
					dv_quot_s[k] <= quot_p;
				end
			end
		end
	end

	assign magq  = dv_ovf_s[QB-1] ? '1 : dv_quot_s[QB-1];
	assign mag_x = $signed(SUM_W'(magq));
	assign sv    = dv_neg_s[QB-1] ? -mag_x : mag_x;
	assign sum   = sv + SUM_W'(mean_i);

	always_comb begin
		if (sum > HI) begin
			sample_n = SAMPLE_WIDTH'(HI);
		end else if (sum < LO) begin
			sample_n = SAMPLE_WIDTH'(LO);
		end else begin
			sample_n = SAMPLE_WIDTH'(sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sf <= 1'b0;
		end else if (adv) begin
			vld_sf <= dv_vld_s[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_s <= sample_n;
		end
	end

	assign vld_o    = vld_sf;
	assign sample_o = sample_s;

endmodule

@@ sv/polar_gaussian_noise_top.sv @@
// polar gaussian noise generator, top level; depends on pgn_pkg, pgn_isqrt, pgn_log, pgn_lane
// results: first sample after the input register and the q root, log, s root and lane pipelines,
// second sample on the following cycle; rejected pairs give no result
// throughput: one item per cycle while busy is low; an accepted pair holds the output for both its samples,
// so busy rises for one cycle when a second sample still waits; results cannot be stalled
// reset: valid bits and the output slot clear, mean_offset 0, std_scale 4096
module polar_gaussian_noise_top #(
	parameter int UNIFORM_WIDTH = 16,
	parameter int SAMPLE_WIDTH  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [UNIFORM_WIDTH-1:0] uniform_x,
	input  logic signed [UNIFORM_WIDTH-1:0] uniform_y,
	input  logic                            cfg_we,
	input  logic                            cfg_idx,
	input  logic [pgn_pkg::CFG_W-1:0]       cfg_wdata,
	output logic                            strobe,
	output logic signed [SAMPLE_WIDTH-1:0]  normal_sample,
	output logic                            last_of_pair
);
	import pgn_pkg::*;

	localparam int QRAD_W = 2 * QROOT_W;
	localparam int SRAD_W = 2 * SROOT_W;

	logic signed [MEAN_W-1:0] mean_q;
	logic [SCALE_W-1:0]       scale_q;

	q15_t               xq_n;
	q15_t               yq_n;
	logic signed [31:0] sqx_n;
	logic signed [31:0] sqy_n;
	q15_t               xq_s1;
	q15_t               yq_s1;
	logic [31:0]        r_s1;
	logic               vld_s1;
	logic               keep;
	logic               adv;

	pair_t               pr_in;
	pair_t               pr_out;
	logic                q_vld;
	logic [QROOT_W-1:0]  q_root;
	coord_t              lg_in;
	coord_t              lg_out;
	logic                lg_vld;
	logic [E_W-1:0]      lg_e;
	coord_t              sr_out;
	logic                sr_vld;
	logic [SROOT_W-1:0]  s_root;

	logic                          vx;
	logic                          vy;
	logic                          vld_lane;
	logic signed [SAMPLE_WIDTH-1:0] smp_x;
	logic signed [SAMPLE_WIDTH-1:0] smp_y;
	logic                          pend_q;
	logic signed [SAMPLE_WIDTH-1:0] pend_smp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q  <= '0;
			scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MEAN: begin
					mean_q <= $signed(cfg_wdata[MEAN_W-1:0]);
				end
				REG_SCALE: begin
					scale_q <= cfg_wdata[SCALE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// bring inputs to q1.15
	if (UNIFORM_WIDTH > Q15_W) begin : g_narrow
		assign xq_n = uniform_x[UNIFORM_WIDTH-1:UNIFORM_WIDTH-Q15_W];
		assign yq_n = uniform_y[UNIFORM_WIDTH-1:UNIFORM_WIDTH-Q15_W];
	end else if (UNIFORM_WIDTH < Q15_W) begin : g_widen
		assign xq_n = {uniform_x, {(Q15_W-UNIFORM_WIDTH){1'b0}}};
		assign yq_n = {uniform_y, {(Q15_W-UNIFORM_WIDTH){1'b0}}};
	end else begin : g_same
		assign xq_n = uniform_x;
		assign yq_n = uniform_y;
	end

	assign sqx_n = xq_n * xq_n;
	assign sqy_n = yq_n * yq_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xq_s1 <= xq_n;
			yq_s1 <= yq_n;
			r_s1  <= $unsigned(sqx_n) + $unsigned(sqy_n);
		end
	end

	// reject r of zero or above one
	assign keep  = (r_s1 != 32'd0) && (r_s1 <= (32'd1 << 30));
	assign pr_in = '{x: xq_s1, y: yq_s1, r: r_s1[RAD_BITS-1:0]};

	pgn_isqrt #(
		.RAD_W  (QRAD_W),
		.SIDE_W ($bits(pair_t))
	) u_qroot (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld_i  (vld_s1 && keep),
		.rad_i  ({1'b0, r_s1[RAD_BITS-1:0], 30'd0}),
		.side_i (pr_in),
		.vld_o  (q_vld),
		.root_o (q_root),
		.side_o (pr_out)
	);

	assign lg_in = '{x: pr_out.x, y: pr_out.y, q: q_root};

	pgn_log #(
		.SIDE_W ($bits(coord_t))
	) u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld_i  (q_vld),
		.r_i    (pr_out.r),
		.side_i (lg_in),
		.vld_o  (lg_vld),
		.e_o    (lg_e),
		.side_o (lg_out)
	);

	pgn_isqrt #(
		.RAD_W  (SRAD_W),
		.SIDE_W ($bits(coord_t))
	) u_sroot (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld_i  (lg_vld),
		.rad_i  ({lg_e, 16'd0}),
		.side_i (lg_out),
		.vld_o  (sr_vld),
		.root_o (s_root),
		.side_o (sr_out)
	);

	pgn_lane #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_lane_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vld_i    (sr_vld),
		.coord_i  (sr_out.x),
		.s_i      (s_root),
		.q_i      (sr_out.q),
		.scale_i  (scale_q),
		.mean_i   (mean_q),
		.vld_o    (vx),
		.sample_o (smp_x)
	);

	pgn_lane #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_lane_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vld_i    (sr_vld),
		.coord_i  (sr_out.y),
		.s_i      (s_root),
		.q_i      (sr_out.q),
		.scale_i  (scale_q),
		.mean_i   (mean_q),
		.vld_o    (vy),
		.sample_o (smp_y)
	);

	assign vld_lane = vx && vy;

	// second sample of a pair waits in the output slot while the first is shown
	assign adv  = !(pend_q && vld_lane);
	assign busy = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (pend_q) begin
			pend_q <= 1'b0;
		end else begin
			pend_q <= vld_lane;
		end
	end

	always_ff @(posedge clk) begin
		if (!pend_q && vld_lane) begin
			pend_smp_q <= smp_y;
		end
	end

	assign strobe        = pend_q || vld_lane;
	assign normal_sample = pend_q ? pend_smp_q : smp_x;
	assign last_of_pair  = pend_q;

	a_pend_one: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |=> !pend_q)
		else $error("output slot held a second sample for more than one cycle");

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last_of_pair) |=> (strobe && last_of_pair))
		else $error("first sample of an item not followed by its second");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (pend_q && vld_lane))
		else $error("pipeline stalled without a pending second sample");

endmodule

@@ tb/sv/tb_polar_gaussian_noise_top.sv @@
// testbench for polar_gaussian_noise_top: directed and random uniform pairs, register phases
// predicts gaussian samples with an in-bench fixed point model; depends on pgn_pkg and the rtl
`timescale 1ns / 100ps

module tb_polar_gaussian_noise_top;
	import pgn_pkg::*;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
	} pair_item_t;

	typedef struct {
		logic signed [15:0] smp;
		logic               last;
	} sample_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic signed [15:0] uniform_x = '0;
	logic signed [15:0] uniform_y = '0;
	logic              cfg_we = 1'b0;
	logic              cfg_idx = REG_MEAN;
	logic [CFG_W-1:0]  cfg_wdata = '0;
	logic              strobe;
	logic signed [15:0] normal_sample;
	logic              last_of_pair;

	pair_item_t pending_pairs[$];
	sample_t    expected_samples[$];
	int         errors = 0;
	bit         drv_active = 1'b0;
	int         gap_left = 0;
	logic       accepted = 1'b0;

	logic signed [16:0] model_mean = 0;
	logic [14:0]        model_scale = 15'd4096;

	polar_gaussian_noise_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.uniform_x(uniform_x), .uniform_y(uniform_y),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.strobe(strobe), .normal_sample(normal_sample), .last_of_pair(last_of_pair)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [63:0] int_sqrt(input logic [63:0] n);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic signed [15:0] scaled_sample(input longint v, input logic [63:0] s,
			input logic [63:0] q);
		logic [63:0] mag, num;
		longint smp;
		mag = (v < 0) ? -v : v;
		num = mag * s * model_scale + q;
		smp = longint'(num / (2 * q));
		if (v < 0) smp = -smp;
		smp += model_mean;
		if (smp > 32767) smp = 32767;
		if (smp < -32768) smp = -32768;
		return smp[15:0];
	endfunction

	task automatic predict_gaussian(input pair_item_t it);
		longint x, y;
		logic [63:0] r, m, frac, l, e, s, q;
		int p;
		sample_t a, b;
		x = it.x;
		y = it.y;
		r = x * x + y * y;
		if (r == 0 || r > (64'd1 << 30)) return;
		p = 0;
		while (p < 30 && (r >> (p + 1)) != 0) p++;
		m = r << (30 - p);
		frac = 0;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac <<= 1;
			if (m >= (64'd1 << 31)) begin
				m >>= 1;
				frac |= 1;
			end
		end
		l = (64'(30 - p) << 16) - frac;
		e = (l * 64'd1488522236) >> 30;
		s = int_sqrt(e << 16);
		q = int_sqrt(r << 30);
		a.smp = scaled_sample(x, s, q);
		a.last = 1'b0;
		b.smp = scaled_sample(y, s, q);
		b.last = 1'b1;
		expected_samples.push_back(a);
		expected_samples.push_back(b);
	endtask

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 50) return 0;
		if (k < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// item taken at a rising edge with start high and busy low
	always @(posedge clk) begin
		accepted <= start && !busy;
	end

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (drv_active && start && !accepted) begin
				// item still waiting
			end else begin
				if (drv_active && start) predict_gaussian('{uniform_x, uniform_y});
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
					drv_active <= 1'b1;
				end else if (pending_pairs.size() > 0) begin
					pair_item_t it;
					it = pending_pairs.pop_front();
					uniform_x <= it.x;
					uniform_y <= it.y;
					start <= 1'b1;
					drv_active <= 1'b1;
					gap_left <= pick_gap();
				end else begin
					start <= 1'b0;
					drv_active <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (expected_samples.size() == 0) begin
				$display("%0t unexpected sample: expected none, actual %0d last %0b",
					$time, normal_sample, last_of_pair);
				errors++;
			end else begin
				sample_t ex;
				ex = expected_samples.pop_front();
				if (normal_sample !== ex.smp) begin
					$display("%0t normal_sample mismatch: expected %0d, actual %0d",
						$time, ex.smp, normal_sample);
					errors++;
				end
				if (last_of_pair !== ex.last) begin
					$display("%0t last_of_pair mismatch: expected %0b, actual %0b",
						$time, ex.last, last_of_pair);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MEAN) model_mean = $signed(val);
		else model_scale = val[14:0];
	endtask

	task automatic wait_drained();
		while (pending_pairs.size() > 0 || drv_active || expected_samples.size() > 0)
			@(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	task automatic add_pair(input logic [15:0] x, input logic [15:0] y);
		pending_pairs.push_back('{x, y});
	endtask

	task automatic add_random(input int n);
		logic signed [15:0] x, y;
		for (int i = 0; i < n; i++) begin
			x = 16'($urandom);
			y = 16'($urandom);
			if ($urandom_range(0, 9) < 7) begin
				while (longint'(x) * longint'(x) + longint'(y) * longint'(y) > (64'd1 << 30)
						|| (x == 0 && y == 0)) begin
					x = 16'($urandom);
					y = 16'($urandom);
				end
			end
			if ($urandom_range(0, 29) == 0) x = 16'sd0;
			add_pair(x, y);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		add_pair(16'h8000, 16'h0000);
		add_pair(16'h0000, 16'h8000);
		add_pair(16'h0000, 16'h0000);
		add_pair(16'h7fff, 16'h7fff);
		add_pair(16'h8000, 16'h8000);
		add_pair(16'h0001, 16'h0000);
		add_pair(16'h0000, 16'hffff);
		add_pair(16'h0001, 16'h0001);
		add_pair(16'h5a82, 16'h5a82);
		add_pair(16'h5a83, 16'h5a83);
		add_pair(16'h4000, 16'hc000);
		add_pair(16'h0000, 16'h2000);
		add_pair(16'h7fff, 16'h0000);
		add_pair(16'hffff, 16'hffff);
		add_pair(16'h1234, 16'h8765);
		add_pair(16'h5555, 16'haaaa);
		add_random(130);
		wait_drained();
		write_reg(REG_SCALE, 16'h7fff);
		write_reg(REG_MEAN, 16'h7fff);
		add_pair(16'h0001, 16'h0000);
		add_pair(16'h0010, 16'hfff0);
		add_random(150);
		wait_drained();
		write_reg(REG_MEAN, 16'h8000);
		add_random(150);
		wait_drained();
		write_reg(REG_SCALE, 16'h0000);
		write_reg(REG_MEAN, 16'h1234);
		add_random(100);
		wait_drained();
		write_reg(REG_SCALE, 16'h1000);
		write_reg(REG_MEAN, 16'h0000);
		add_random(200);
		wait_drained();
		write_reg(REG_SCALE, 16'h0a5b);
		write_reg(REG_MEAN, 16'hf1c3);
		add_random(200);
		wait_drained();
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
